@@ src/etc1_pkg.sv @@
// ----------------------------------------------------------------------------
// etc1_pkg
// shared types, constants and the modifier table for the etc1 block decoder
// ----------------------------------------------------------------------------
package etc1_pkg;

  localparam int unsigned TexelsPerBlock = 16;
  localparam int unsigned TexelIdxW      = 4;

  // control word bit positions
  localparam int unsigned CtlFlipBit = 0;
  localparam int unsigned CtlDiffBit = 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // widened base colors of the two sub-blocks
  typedef struct packed {
    color_t     one;
    color_t     two;
    logic [2:0] tab_one;
    logic [2:0] tab_two;
    logic       flip;
  } bases_t;

  typedef struct packed {
    color_t     color;
    logic [7:0] alpha;
    logic [1:0] column;
    logic [1:0] row;
    logic       last_texel;
  } texel_t;

  // modifier magnitude, small row when lo is 0, large row when lo is 1
  function automatic logic [7:0] mod_mag(input logic lo, input logic [2:0] tab);
    logic [7:0] m;
    unique case ({lo, tab})
      4'h0: m = 8'd2;
      4'h1: m = 8'd5;
      4'h2: m = 8'd9;
      4'h3: m = 8'd13;
      4'h4: m = 8'd18;
      4'h5: m = 8'd24;
      4'h6: m = 8'd33;
      4'h7: m = 8'd47;
      4'h8: m = 8'd8;
      4'h9: m = 8'd17;
      4'hA: m = 8'd29;
      4'hB: m = 8'd42;
      4'hC: m = 8'd60;
      4'hD: m = 8'd80;
      4'hE: m = 8'd106;
      4'hF: m = 8'd183;
      default: m = 8'd0;
    endcase
    return m;
  endfunction

endpackage

@@ src/etc1_block_texel_decoder_core.sv @@
// ----------------------------------------------------------------------------
// etc1_block_texel_decoder_core
// etc1 4x4 block decoder emitting sixteen rgba8 texels per block
// ----------------------------------------------------------------------------
// usage:
//   - a block transaction is taken at a rising edge with start_i high and
//     busy_o low; index_bits_i, control_word_i and alpha_bits_i are captured
//   - results come out one texel per cycle in row-major order, each marked
//     by result_valid_o for exactly one cycle; last_texel_o flags texel 15
//   - the first texel is computed from the block register and reaches the
//     ports through the result register
//   - blocks are taken one at a time, set by the single texel path behind
//     the block register; busy_o drops during the cycle texel 15 is
//     computed so the next block loads with no gap on the result stream
//   - the receiver cannot stall; results are never held back
//   - cfg channel: with_alpha is written when cfg_valid_i and cfg_ready_o
//     are both high; write it only while no block is in flight
//   - reset clears the sequencer, the result strobe and with_alpha to 0
// ----------------------------------------------------------------------------
module etc1_block_texel_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // block transaction
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] index_bits_i,
  input  logic [31:0] control_word_i,
  input  logic [63:0] alpha_bits_i,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // texel results
  output logic        result_valid_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [1:0]  column_o,
  output logic [1:0]  row_o,
  output logic        last_texel_o
);

  localparam logic [etc1_pkg::TexelIdxW-1:0] LastIdx =
    etc1_pkg::TexelIdxW'(etc1_pkg::TexelsPerBlock - 1);

  logic                            accept;
  logic                            active_d, active_q;
  logic [etc1_pkg::TexelIdxW-1:0]  cnt_d, cnt_q;
  logic                            with_alpha_q;
  logic [31:0]                     index_q;
  logic [31:0]                     ctl_q;
  logic [63:0]                     abits_q;
  etc1_pkg::bases_t                bases;
  etc1_pkg::texel_t                texel;
  etc1_pkg::texel_t                res_q;
  logic                            res_valid_q;

  // busy releases on the final texel so blocks run back to back
  assign busy_o      = active_q && (cnt_q != LastIdx);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // texel sequencer
  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (accept) begin
      active_d = 1'b1;
      cnt_d    = '0;
    end else if (active_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastIdx) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      cnt_q        <= '0;
      with_alpha_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      res_valid_q <= active_q;
      if (cfg_valid_i && cfg_ready_o) begin
        with_alpha_q <= cfg_data_i;
      end
    end
  end

  // block register, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      index_q <= index_bits_i;
      ctl_q   <= control_word_i;
      abits_q <= alpha_bits_i;
    end
  end

  etc1_base_dec u_base_dec (
    .control_word_i (ctl_q),
    .bases_o        (bases)
  );

  etc1_texel u_texel (
    .bases_i      (bases),
    .index_bits_i (index_q),
    .alpha_bits_i (abits_q),
    .with_alpha_i (with_alpha_q),
    .texel_i      (cnt_q),
    .texel_o      (texel)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (active_q) begin
      res_q <= texel;
    end
  end

  assign result_valid_o = res_valid_q;
  assign red_o          = res_q.color.red;
  assign green_o        = res_q.color.green;
  assign blue_o         = res_q.color.blue;
  assign alpha_o        = res_q.alpha;
  assign column_o       = res_q.column;
  assign row_o          = res_q.row;
  assign last_texel_o   = res_q.last_texel;

endmodule

@@ src/etc1_base_dec.sv @@
// ----------------------------------------------------------------------------
// etc1_base_dec
// decodes the control word into the two widened sub-block base colors
// ----------------------------------------------------------------------------
module etc1_base_dec (
  input  logic [31:0]     control_word_i,
  output etc1_pkg::bases_t bases_o
);

  logic diff;

  function automatic logic [7:0] widen5(input logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  // one color byte into base one and base two
  function automatic logic [15:0] dec_byte(input logic [7:0] b, input logic d);
    logic [4:0] b1;
    logic [4:0] b2;
    logic [15:0] r;
    b1 = b[7:3];
    b2 = b1 + {{2{b[2]}}, b[2:0]};  // wraps to 5 bits
    if (d) begin
      r = {widen5(b1), widen5(b2)};
    end else begin
      r = {b[7:4], b[7:4], b[3:0], b[3:0]};  // nibble times 17
    end
    return r;
  endfunction

  logic [15:0] red_pair;
  logic [15:0] green_pair;
  logic [15:0] blue_pair;

  assign diff       = control_word_i[etc1_pkg::CtlDiffBit];
  assign red_pair   = dec_byte(control_word_i[31:24], diff);
  assign green_pair = dec_byte(control_word_i[23:16], diff);
  assign blue_pair  = dec_byte(control_word_i[15:8], diff);

  always_comb begin
    bases_o.one.red    = red_pair[15:8];
    bases_o.one.green  = green_pair[15:8];
    bases_o.one.blue   = blue_pair[15:8];
    bases_o.two.red    = red_pair[7:0];
    bases_o.two.green  = green_pair[7:0];
    bases_o.two.blue   = blue_pair[7:0];
    bases_o.tab_one    = control_word_i[7:5];
    bases_o.tab_two    = control_word_i[4:2];
    bases_o.flip       = control_word_i[etc1_pkg::CtlFlipBit];
  end

endmodule

@@ src/etc1_texel.sv @@
// ----------------------------------------------------------------------------
// etc1_texel
// computes one texel from the block bases, index bits and alpha nibbles
// ----------------------------------------------------------------------------
module etc1_texel (
  input  etc1_pkg::bases_t                  bases_i,
  input  logic [31:0]                       index_bits_i,
  input  logic [63:0]                       alpha_bits_i,
  input  logic                              with_alpha_i,
  input  logic [etc1_pkg::TexelIdxW-1:0]    texel_i,     // row-major {row, column}
  output etc1_pkg::texel_t                  texel_o
);

  logic [1:0] col;
  logic [1:0] row;
  logic [3:0] k;
  logic       lo;
  logic       hi;
  logic       sub;
  logic [2:0] tab;
  logic [7:0] mag;
  logic [9:0] offs;
  logic [3:0] nib;
  etc1_pkg::color_t base;

  function automatic logic [7:0] add_clamp(input logic [7:0] b, input logic [9:0] o);
    logic [9:0] s;
    logic [7:0] r;
    s = {2'b00, b} + o;
    if (s[9]) begin
      r = 8'd0;
    end else if (s[8]) begin
      r = 8'd255;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

  assign row = texel_i[3:2];
  assign col = texel_i[1:0];
  assign k   = {col, row};  // column-major bit position
  assign lo  = index_bits_i[{1'b0, k}];
  assign hi  = index_bits_i[{1'b1, k}];
  assign sub = bases_i.flip ? row[1] : col[1];
  assign tab = sub ? bases_i.tab_two : bases_i.tab_one;
  assign base = sub ? bases_i.two : bases_i.one;
  assign mag = etc1_pkg::mod_mag(lo, tab);
  assign offs = hi ? (10'd0 - {2'b00, mag}) : {2'b00, mag};
  // nibble index equals k: byte col*2+row/2, high nibble on odd rows
  assign nib = alpha_bits_i[{k, 2'b00} +: 4];

  always_comb begin
    texel_o.color.red   = add_clamp(base.red, offs);
    texel_o.color.green = add_clamp(base.green, offs);
    texel_o.color.blue  = add_clamp(base.blue, offs);
    texel_o.alpha       = with_alpha_i ? {nib, nib} : 8'hFF;
    texel_o.column      = col;
    texel_o.row         = row;
    texel_o.last_texel  = (col == 2'd3) && (row == 2'd3);
  end

endmodule

@@ src/etc1_checker.sv @@
// ----------------------------------------------------------------------------
// etc1_checker
// port-level checks on the etc1 block decoder result stream
// ----------------------------------------------------------------------------
module etc1_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_valid_o,
  input logic [1:0] column_o,
  input logic [1:0] row_o,
  input logic       last_texel_o
);

  // an accepted block starts its texel stream at column 0, row 0
  a_first_texel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 (result_valid_o && column_o == 2'd0 && row_o == 2'd0))
    else $error("block did not start at texel 0");

  // texels of one block are contiguous
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_texel_o) |=> result_valid_o)
    else $error("gap inside a block texel stream");

  // the last flag sits on the bottom-right texel only
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_texel_o == (column_o == 2'd3 && row_o == 2'd3)))
    else $error("last_texel mismatch with position");

  // busy only rises after a block transaction
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a start");

endmodule

bind etc1_block_texel_decoder_core etc1_checker u_etc1_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .column_o       (column_o),
  .row_o          (row_o),
  .last_texel_o   (last_texel_o)
);
